>>> src/audio_crossfade_volume_controller_core_defines.svh
// ---------------------------------------------------------------------------
// audio crossfade volume controller assertion macros
// shared helpers for the concurrent checks in the rtl
// ---------------------------------------------------------------------------
`ifndef AUDIO_CROSSFADE_VOLUME_CONTROLLER_CORE_DEFINES_SVH
`define AUDIO_CROSSFADE_VOLUME_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define ACVC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACVC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/acvc_pkg.sv
// ---------------------------------------------------------------------------
// acvc_pkg
// types and constants of the crossfade volume controller
// ---------------------------------------------------------------------------
package acvc_pkg;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_PLAY   = 3'd1;
  localparam logic [2:0] MODE_STOP   = 3'd2;
  localparam logic [2:0] MODE_SETVOL = 3'd3;
  localparam logic [2:0] MODE_XFADE  = 3'd4;

  localparam logic [15:0] STOP_FADE_MS = 16'd500;
  localparam int          DUR_W        = 16;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PLAYING  = 3'd1,
    PH_STOPPING = 3'd2,
    PH_FADE_OUT = 3'd3,
    PH_FADE_IN  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_STEP
  } div_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] value;
    logic [7:0]  track;
    logic        load_ok;
  } in_word_t;

  typedef struct packed {
    logic       volume_write;
    logic [4:0] volume;
    logic       start_track;
    logic [7:0] track_out;
    logic       stop_song;
    logic [2:0] phase_out;
  } out_word_t;

endpackage

>>> src/acvc_div.sv
// ---------------------------------------------------------------------------
// acvc_div
// ramp unit: one multiply v*m, then a restoring divide by d, one bit a cycle
// ---------------------------------------------------------------------------
module acvc_div #(
  parameter int VW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [VW-1:0]               v,
  input  logic [acvc_pkg::DUR_W-1:0]  m,
  input  logic [acvc_pkg::DUR_W-1:0]  d,
  output logic                        done,
  output logic [VW-1:0]               q
);
  import acvc_pkg::*;

  localparam int NW = VW + DUR_W;
  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  div_state_t        dst, dst_next;
  logic [VW-1:0]     vreg;
  logic [DUR_W-1:0]  mreg;
  logic [DUR_W-1:0]  den;
  logic [NW-1:0]     num;
  logic [DUR_W-1:0]  rem;
  logic [CW-1:0]     cnt;
  logic [DUR_W:0]    shifted;
  logic              fits;

  assign shifted = {rem, num[NW-1]};
  assign fits    = (shifted >= {1'b0, den});
  assign q       = num[VW-1:0];

  always_comb begin
    dst_next = dst;
    case (dst)
      D_IDLE: if (start) dst_next = D_MUL;
      D_MUL:  dst_next = D_STEP;
      D_STEP: if (cnt == '0) dst_next = D_IDLE;
      default: dst_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst  <= D_IDLE;
      done <= 1'b0;
    end else begin
      dst  <= dst_next;
      done <= (dst == D_STEP) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (dst)
      D_IDLE: if (start) begin
        vreg <= v;
        mreg <= m;
        den  <= d;
      end
      D_MUL: begin
        num <= NW'(vreg * mreg);
        rem <= '0;
        cnt <= CW'(NW - 1);
      end
      D_STEP: begin
        // quotient bits shift in from the bottom as numerator bits leave
        if (fits) begin
          rem <= DUR_W'(shifted - {1'b0, den});
        end else begin
          rem <= shifted[DUR_W-1:0];
        end
        num <= {num[NW-2:0], fits};
        cnt <= cnt - CW'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> src/audio_crossfade_volume_controller_core.sv
// ---------------------------------------------------------------------------
// audio_crossfade_volume_controller_core
// playback volume sequencer: commands and ms ticks in, one result word out
// ---------------------------------------------------------------------------
// flow: S_EVAL, then S_DIV for a ramp value, then S_DONE until the output is free
//   divider numerator NW = clog2(MAX_VOLUME+1)+16 bits (21 at defaults)
// in_ready is high only in S_IDLE: no new word until the last result is loaded
// reset: synchronous; idle phase, volume MAX_VOLUME, fade DEFAULT_FADE_MS,
//   elapsed 0, no result pending
module audio_crossfade_volume_controller_core #(
  parameter int MAX_VOLUME      = 21,
  parameter int DEFAULT_FADE_MS = 1000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  acvc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acvc_pkg::out_word_t out_data
);
  import acvc_pkg::*;

  `include "audio_crossfade_volume_controller_core_defines.svh"

  localparam int VW = (MAX_VOLUME > 1) ? $clog2(MAX_VOLUME + 1) : 1;

  seq_state_t        st, st_next;
  phase_t            phase, phase_next;
  logic [VW-1:0]     vol_set, vol_set_next;
  logic [DUR_W-1:0]  fade_dur, fade_dur_next;
  logic [DUR_W-1:0]  elapsed, elapsed_next;
  logic [7:0]        pend, pend_next;
  logic              ld_ok, ld_ok_next;
  out_word_t         res, res_next;
  out_word_t         out_data_next;
  logic              out_valid_next;
  logic              out_load;

  logic              div_start;
  logic [DUR_W-1:0]  div_m;
  logic              div_done;
  logic [VW-1:0]     div_q;

  logic [VW-1:0]     vol_sat;
  logic [DUR_W-1:0]  half;
  logic [DUR_W-1:0]  e2;

  assign in_ready = (st == S_IDLE);
  assign vol_sat  = (in_data.value > DUR_W'(MAX_VOLUME)) ? VW'(MAX_VOLUME)
                                                          : VW'(in_data.value);
  assign half     = fade_dur >> 1;
  // only used while elapsed < half, so the doubled value fits
  assign e2       = {elapsed[DUR_W-2:0], 1'b0};

  acvc_div #(.VW(VW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .v     (vol_set),
    .m     (div_m),
    .d     (fade_dur),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    st_next        = st;
    phase_next     = phase;
    vol_set_next   = vol_set;
    fade_dur_next  = fade_dur;
    elapsed_next   = elapsed;
    pend_next      = pend;
    ld_ok_next     = ld_ok;
    res_next       = res;
    out_data_next  = out_data;
    out_load       = 1'b0;
    div_start      = 1'b0;
    div_m          = '0;
    case (st)
      S_IDLE: if (in_valid) begin
        res_next   = '0;
        ld_ok_next = in_data.load_ok;
        st_next    = S_EVAL;
        case (in_data.mode)
          MODE_TICK: begin
            if (elapsed != '1) elapsed_next = elapsed + DUR_W'(1);
          end
          MODE_PLAY: begin
            res_next.start_track  = 1'b1;
            res_next.track_out    = in_data.track;
            res_next.volume_write = 1'b1;
            res_next.volume       = 5'(vol_set);
            phase_next            = PH_PLAYING;
          end
          MODE_STOP: begin
            elapsed_next  = '0;
            fade_dur_next = STOP_FADE_MS;
            phase_next    = PH_STOPPING;
          end
          MODE_SETVOL: begin
            vol_set_next = vol_sat;
            if (phase == PH_PLAYING) begin
              res_next.volume_write = 1'b1;
              res_next.volume       = 5'(vol_sat);
            end
          end
          MODE_XFADE: begin
            if (phase == PH_PLAYING || phase == PH_FADE_IN) begin
              pend_next    = in_data.track;
              elapsed_next = '0;
              if (in_data.value != '0) fade_dur_next = in_data.value;
              phase_next   = PH_FADE_OUT;
            end else begin
              res_next.start_track  = 1'b1;
              res_next.track_out    = in_data.track;
              res_next.volume_write = 1'b1;
              res_next.volume       = 5'(vol_set);
              phase_next            = PH_PLAYING;
            end
          end
          default: ;
        endcase
      end
      S_EVAL: begin
        st_next = S_DONE;
        case (phase)
          PH_STOPPING: begin
            if (elapsed >= fade_dur) begin
              res_next.volume_write = 1'b1;
              res_next.volume       = '0;
              res_next.stop_song    = 1'b1;
              phase_next            = PH_IDLE;
            end else begin
              div_start = 1'b1;
              div_m     = fade_dur - elapsed;
              st_next   = S_DIV;
            end
          end
          PH_FADE_OUT: begin
            if (elapsed >= half) begin
              res_next.volume_write = 1'b1;
              res_next.volume       = '0;
              if (ld_ok) begin
                res_next.start_track = 1'b1;
                res_next.track_out   = pend;
                phase_next           = PH_FADE_IN;
                elapsed_next         = '0;
              end else begin
                phase_next = PH_IDLE;
              end
            end else begin
              div_start = 1'b1;
              div_m     = fade_dur - e2;
              st_next   = S_DIV;
            end
          end
          PH_FADE_IN: begin
            if (elapsed >= half) begin
              res_next.volume_write = 1'b1;
              res_next.volume       = 5'(vol_set);
              phase_next            = PH_PLAYING;
            end else begin
              div_start = 1'b1;
              div_m     = e2;
              st_next   = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_DIV: if (div_done) begin
        res_next.volume_write = 1'b1;
        res_next.volume       = 5'(div_q);
        st_next               = S_DONE;
      end
      S_DONE: if (!out_valid || out_ready) begin
        out_load                = 1'b1;
        out_data_next           = res;
        out_data_next.phase_out = phase;
        st_next                 = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      phase     <= PH_IDLE;
      vol_set   <= VW'(MAX_VOLUME);
      fade_dur  <= DUR_W'(DEFAULT_FADE_MS);
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      phase     <= phase_next;
      vol_set   <= vol_set_next;
      fade_dur  <= fade_dur_next;
      elapsed   <= elapsed_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend     <= pend_next;
    ld_ok    <= ld_ok_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  `ACVC_ASSERT_NXT(a_accept_evaluates, clk, rst, in_valid && in_ready, st == S_EVAL,
    "accepted word did not enter evaluation")
  `ACVC_ASSERT_IMP(a_result_from_done, clk, rst, $rose(out_valid), $past(st) == S_DONE,
    "result word loaded outside the done state")
  `ACVC_ASSERT_IMP(a_stop_ends_idle, clk, rst, out_valid && out_data.stop_song,
    out_data.phase_out == PH_IDLE, "stop_song without idle phase")
  `ACVC_ASSERT_IMP(a_quiet_volume, clk, rst, out_valid && !out_data.volume_write,
    out_data.volume == 5'd0, "volume field set without a volume write")

endmodule

>>> verif/audio_crossfade_volume_controller_core_test.sv
// ---------------------------------------------------------------------------
// audio_crossfade_volume_controller_core_test
// drives command and tick words through the volume sequencer and checks
// every result word against a cycle-free behavioral predictor
// ---------------------------------------------------------------------------
module audio_crossfade_volume_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acvc_pkg::*;

  localparam int          VOL_MAX         = 21;
  localparam int          FADE_DEFAULT_MS = 1000;
  localparam logic [2:0]  MODE_SPARE_LO   = 3'd5;
  localparam logic [2:0]  MODE_SPARE_MID  = 3'd6;
  localparam logic [2:0]  MODE_SPARE_HI   = 3'd7;
  localparam int          CLK_HALF        = 4;
  localparam int          RESET_CYCLES    = 6;
  localparam int          RANDOM_WORDS    = 450;
  localparam int          IDLE_PCT        = 36;
  localparam int          HOLD_AT         = 60;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          RAMP_TICK_CAP   = 60;
  localparam longint      LIMIT_NS        = 4_000_000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  in_word_t  cmd_q[$];
  out_word_t result_q[$];

  // predictor state
  phase_t      m_phase;
  logic [4:0]  m_vol_set;
  logic [15:0] m_fade_ms;
  logic [15:0] m_elapsed;
  logic [7:0]  m_pending;

  int n_errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_queued = 0;
  int n_stop_ends = 0;
  int n_fade_ins = 0;
  int n_load_fails = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned gen_fade = FADE_DEFAULT_MS;

  audio_crossfade_volume_controller_core #(
    .MAX_VOLUME      (VOL_MAX),
    .DEFAULT_FADE_MS (FADE_DEFAULT_MS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // one command or tick applied to the sequencer, then the ramp evaluated
  function automatic out_word_t sequencer_step(input in_word_t w);
    out_word_t   r;
    int unsigned d, e, v, lvl;
    r = '0;
    case (w.mode)
      MODE_TICK: begin
        if (m_elapsed != 16'hFFFF) m_elapsed = m_elapsed + 16'd1;
      end
      MODE_PLAY: begin
        r.start_track  = 1'b1;
        r.track_out    = w.track;
        r.volume_write = 1'b1;
        r.volume       = m_vol_set;
        m_phase        = PH_PLAYING;
      end
      MODE_STOP: begin
        m_elapsed = '0;
        m_fade_ms = STOP_FADE_MS;
        m_phase   = PH_STOPPING;
      end
      MODE_SETVOL: begin
        m_vol_set = (w.value > VOL_MAX) ? 5'(VOL_MAX) : w.value[4:0];
        if (m_phase == PH_PLAYING) begin
          r.volume_write = 1'b1;
          r.volume       = m_vol_set;
        end
      end
      MODE_XFADE: begin
        if (m_phase == PH_PLAYING || m_phase == PH_FADE_IN) begin
          m_pending = w.track;
          m_elapsed = '0;
          if (w.value != '0) m_fade_ms = w.value;
          m_phase = PH_FADE_OUT;
        end else begin
          // nothing to fade from: start right away
          r.start_track  = 1'b1;
          r.track_out    = w.track;
          r.volume_write = 1'b1;
          r.volume       = m_vol_set;
          m_phase        = PH_PLAYING;
        end
      end
      default: ;
    endcase

    d = m_fade_ms;
    e = m_elapsed;
    v = m_vol_set;
    case (m_phase)
      PH_STOPPING: begin
        r.volume_write = 1'b1;
        if (e >= d) begin
          r.volume    = '0;
          r.stop_song = 1'b1;
          m_phase     = PH_IDLE;
          n_stop_ends++;
        end else begin
          lvl      = (v * (d - e)) / d;
          r.volume = lvl[4:0];
        end
      end
      PH_FADE_OUT: begin
        r.volume_write = 1'b1;
        if (e >= d / 2) begin
          r.volume = '0;
          if (w.load_ok) begin
            r.start_track = 1'b1;
            r.track_out   = m_pending;
            m_phase       = PH_FADE_IN;
            m_elapsed     = '0;
            n_fade_ins++;
          end else begin
            m_phase = PH_IDLE;
            n_load_fails++;
          end
        end else begin
          lvl      = (v * (d - 2 * e)) / d;
          r.volume = lvl[4:0];
        end
      end
      PH_FADE_IN: begin
        r.volume_write = 1'b1;
        if (e >= d / 2) begin
          r.volume = m_vol_set;
          m_phase  = PH_PLAYING;
        end else begin
          lvl = (v * 2 * e) / d;
          if (lvl > v) lvl = v;
          r.volume = lvl[4:0];
        end
      end
      default: ;
    endcase
    r.phase_out = m_phase;
    return r;
  endfunction

  // driver: presents queued words, predicts on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      m_phase   = PH_IDLE;
      m_vol_set = 5'(VOL_MAX);
      m_fade_ms = 16'(FADE_DEFAULT_MS);
      m_elapsed = '0;
      m_pending = '0;
    end else begin
      if (in_valid && in_ready) begin
        result_q.push_back(sequencer_step(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() != 0 &&
            ((n_sent >= 200 && n_sent < 300) || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with one long hold-off so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_results == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (n_results >= 200 && n_results < 300) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      n_results <= n_results + 1;
      if (result_q.size() == 0) begin
        log_error($sformatf("result word %0d arrived with nothing expected: %h",
                            n_results, out_data));
      end else begin
        want = result_q.pop_front();
        if (out_data.volume_write !== want.volume_write)
          log_error($sformatf("word %0d volume_write %b, want %b", n_results,
                              out_data.volume_write, want.volume_write));
        if (out_data.volume !== want.volume)
          log_error($sformatf("word %0d volume %0d, want %0d", n_results,
                              out_data.volume, want.volume));
        if (out_data.start_track !== want.start_track)
          log_error($sformatf("word %0d start_track %b, want %b", n_results,
                              out_data.start_track, want.start_track));
        if (out_data.track_out !== want.track_out)
          log_error($sformatf("word %0d track_out %h, want %h", n_results,
                              out_data.track_out, want.track_out));
        if (out_data.stop_song !== want.stop_song)
          log_error($sformatf("word %0d stop_song %b, want %b", n_results,
                              out_data.stop_song, want.stop_song));
        if (out_data.phase_out !== want.phase_out)
          log_error($sformatf("word %0d phase_out %0d, want %0d", n_results,
                              out_data.phase_out, want.phase_out));
      end
    end
  end

  task automatic push_word(input logic [2:0] mode, input logic [15:0] value,
                           input logic [7:0] track, input logic load_ok);
    in_word_t w;
    w.mode    = mode;
    w.value   = value;
    w.track   = track;
    w.load_ok = load_ok;
    cmd_q.push_back(w);
    n_queued++;
  endtask

  // ticks carry random don't-care fields; load_ok mostly high
  task automatic push_ticks(input int unsigned n);
    repeat (n) push_word(MODE_TICK, 16'($urandom), 8'($urandom), $urandom_range(3) != 0);
  endtask

  task automatic push_play();
    push_word(MODE_PLAY, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic push_setvol();
    if ($urandom_range(1) == 0)
      push_word(MODE_SETVOL, 16'($urandom_range(25)), 8'($urandom), 1'($urandom));
    else
      push_word(MODE_SETVOL, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // mostly short fades so both ramps run to the end
  function automatic logic [15:0] pick_dur();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0 && gen_fade <= RAMP_TICK_CAP) return '0;
    if (r <= 2) return 16'd1;
    if (r == 3) return 16'($urandom_range(300, 100));
    return 16'($urandom_range(40, 2));
  endfunction

  task automatic crossfade_run();
    logic [15:0] dur;
    int unsigned half_ms;
    dur = pick_dur();
    if (dur != '0) gen_fade = dur;
    half_ms = (gen_fade / 2 > RAMP_TICK_CAP) ? RAMP_TICK_CAP : gen_fade / 2;
    push_word(MODE_XFADE, dur, 8'($urandom), $urandom_range(4) != 0);
    push_ticks(half_ms + $urandom_range(2));
    push_ticks(half_ms + $urandom_range(2));
  endtask

  task automatic stop_run();
    push_word(MODE_STOP, 16'($urandom), 8'($urandom), 1'($urandom));
    gen_fade = STOP_FADE_MS;
    push_ticks($urandom_range(30, 1));
  endtask

  initial begin
    // directed: field extremes, unused modes, saturation, shortest fades
    push_word(MODE_TICK, 16'hFFFF, 8'hFF, 1'b1);
    push_word(MODE_SPARE_LO, 16'hFFFF, 8'hFF, 1'b1);
    push_word(MODE_SPARE_MID, 16'h0000, 8'h00, 1'b0);
    push_word(MODE_SPARE_HI, 16'hFFFF, 8'hFF, 1'b1);
    push_word(MODE_SETVOL, 16'hFFFF, 8'h00, 1'b0);   // saturates, idle so no write
    push_word(MODE_STOP, 16'h0000, 8'h00, 1'b0);     // stop from idle
    push_word(MODE_TICK, 16'h0000, 8'h00, 1'b0);
    push_word(MODE_SETVOL, 16'h0000, 8'hFF, 1'b1);   // takes effect in the stop ramp
    push_word(MODE_PLAY, 16'h0000, 8'hFF, 1'b0);
    push_word(MODE_SETVOL, 16'd22, 8'h00, 1'b0);
    push_word(MODE_XFADE, 16'd1, 8'h00, 1'b1);       // half is zero: ends at once
    push_word(MODE_TICK, 16'h0000, 8'h00, 1'b0);
    push_word(MODE_XFADE, 16'd1, 8'h33, 1'b0);       // load fails
    push_word(MODE_XFADE, 16'd3, 8'hA5, 1'b1);       // from idle: plays at once
    push_word(MODE_XFADE, 16'd4, 8'h5A, 1'b1);
    push_word(MODE_TICK, 16'h0000, 8'h00, 1'b1);
    push_word(MODE_TICK, 16'h0000, 8'h00, 1'b1);
    push_word(MODE_TICK, 16'h0000, 8'h00, 1'b1);
    push_word(MODE_XFADE, 16'h0000, 8'hC3, 1'b1);    // from fading in, keeps duration
    push_word(MODE_XFADE, 16'hFFFF, 8'h3C, 1'b1);    // from fading out: plays at once
    push_word(MODE_XFADE, 16'hFFFF, 8'h96, 1'b1);
    push_word(MODE_TICK, 16'hFFFF, 8'hFF, 1'b0);
    push_word(MODE_STOP, 16'hFFFF, 8'hFF, 1'b1);
    push_word(MODE_SETVOL, 16'd7, 8'h00, 1'b0);
    push_word(MODE_TICK, 16'h0000, 8'h00, 1'b0);
    gen_fade = STOP_FADE_MS;

    while (n_queued < RANDOM_WORDS) begin
      case ($urandom_range(9))
        0, 1: begin
          push_play();
          if ($urandom_range(1) == 0) push_setvol();
        end
        2, 3, 4: begin
          if ($urandom_range(3) != 0) push_play();
          crossfade_run();
        end
        5: stop_run();
        6: push_setvol();
        7: begin
          if ($urandom_range(1) == 0)
            push_word(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)),
                      16'($urandom), 8'($urandom), 1'($urandom));
          else
            push_ticks($urandom_range(4, 1));
        end
        8: crossfade_run();
        default: begin
          // volume changes in the middle of the fade-out ramp, then in or after the fade-in
          push_play();
          push_word(MODE_XFADE, 16'd30, 8'($urandom), 1'b1);
          gen_fade = 30;
          push_ticks($urandom_range(14, 1));
          push_setvol();
          push_ticks(25);
          push_setvol();
          push_ticks(20);
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0)
      log_error($sformatf("%0d expected result words never arrived", result_q.size()));

    $display("checked %0d result words for %0d input words", n_results, n_sent);
    $display("stop fades run out: %0d, crossfades into a new track: %0d, failed loads: %0d",
             n_stop_ends, n_fade_ins, n_load_fails);
    if (n_errors == 0) begin
      $display("** audio_crossfade_volume_controller_core: PASSED **");
    end else begin
      $display("** audio_crossfade_volume_controller_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d words sent, %0d results seen", n_sent, n_results);
    $display("** audio_crossfade_volume_controller_core: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/acvc_pkg.sv
src/acvc_div.sv
src/audio_crossfade_volume_controller_core.sv
verif/audio_crossfade_volume_controller_core_test.sv
